### src/dr_pkg.sv
// Shared types, constants and the compact-target decoder for the retarget pipeline.
`timescale 1ns / 1ps

package dr_pkg;

  localparam logic [31:0] MANT_MASK = 32'h007fffff;
  localparam logic [31:0] SIGN_BIT  = 32'h00800000;
  localparam logic [31:0] HIGH_TIER = 32'd10000;
  localparam logic [31:0] MID_TIER  = 32'd5000;

  localparam logic [31:0] RST_SWITCH_HEIGHT = 32'd145000;
  localparam logic [31:0] RST_LIMIT_COMPACT = 32'h1e0fffff;
  localparam logic [19:0] RST_SPAN_BEFORE   = 20'd14400;
  localparam logic [19:0] RST_SPAN_AFTER    = 20'd60;
  localparam logic [19:0] RST_BLOCK_SPACING = 20'd60;

  // Quotient bits resolved by one divider cell.
  localparam int STEPS = 4;
  localparam int TW    = 256;
  localparam int HW    = 32;
  localparam int SPW   = 20;

  typedef enum logic [2:0] {
    REG_SWITCH_HEIGHT = 3'd0,
    REG_LIMIT_COMPACT = 3'd1,
    REG_SPAN_BEFORE   = 3'd2,
    REG_SPAN_AFTER    = 3'd3,
    REG_BLOCK_SPACING = 3'd4
  } reg_idx_t;

  // Position of the leading one of a quotient, found as the cells produce it.
  typedef struct packed {
    logic       found;
    logic [7:0] pos;
  } lead_t;

  // A decoded target is mant << sh.
  typedef struct packed {
    logic        ok;
    logic [22:0] mant;
    logic [7:0]  sh;
  } dec_t;

  typedef struct packed {
    logic [31:0] h;
    logic [31:0] prev;
    logic [31:0] t_last;
    logic [31:0] t_first;
  } hdr_t;

  typedef struct packed {
    hdr_t        hdr;
    logic [19:0] interval;
  } c2_side_t;

  typedef struct packed {
    logic        boundary;
    logic [31:0] start;
    logic [31:0] prev;
    logic        bad;
    logic        ovf;
    logic        span_zero;
  } c3_side_t;

  function automatic dec_t decode(input logic [31:0] bits);
    dec_t        d;
    logic [22:0] m;
    logic [7:0]  e;
    m = bits[22:0];
    e = bits[31:24];
    d.ok = 1'b0;
    d.mant = m;
    d.sh = 8'd0;
    if (!bits[23] && m != 23'd0) begin
      if (e <= 8'd3) begin
        case (e[1:0])
          2'd0: d.mant = 23'd0;
          2'd1: d.mant = m >> 16;
          2'd2: d.mant = m >> 8;
          default: d.mant = m;
        endcase
        d.ok = d.mant != 23'd0;
      end else if (e <= 8'd32) begin
        d.sh = (e - 8'd3) << 3;
        d.ok = 1'b1;
      end else if (e == 8'd33) begin
        d.sh = 8'd240;
        d.ok = m[22:16] == 7'd0;
      end else if (e == 8'd34) begin
        d.sh = 8'd248;
        d.ok = m[22:8] == 15'd0;
      end
    end
    return d;
  endfunction

endpackage

### src/dr_div_cell.sv
// One restoring-division cell: resolves a few quotient bits and passes the word on.
`timescale 1ns / 1ps

module dr_div_cell #(
  parameter int W         = 32,
  parameter int DW        = 20,
  parameter int SW        = 1,
  parameter int FIRST_BIT = 31
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [DW-1:0]   in_rem,
  input  logic [W-1:0]    in_num,
  input  logic [DW-1:0]   in_div,
  input  logic [SW-1:0]   in_side,
  input  dr_pkg::lead_t   in_lead,
  output logic            out_valid,
  output logic [DW-1:0]   out_rem,
  output logic [W-1:0]    out_num,
  output logic [DW-1:0]   out_div,
  output logic [SW-1:0]   out_side,
  output dr_pkg::lead_t   out_lead
);

  logic [DW-1:0] rem_c;
  logic [W-1:0]  num_c;
  dr_pkg::lead_t lead_c;
  logic [DW:0]   r2;
  logic [DW:0]   diff;
  logic          ge;

  // The top of num holds dividend bits still to come; quotient bits enter at the bottom.
  always_comb begin
    rem_c  = in_rem;
    num_c  = in_num;
    lead_c = in_lead;
    r2     = '0;
    diff   = '0;
    ge     = 1'b0;
    for (int j = 0; j < dr_pkg::STEPS; j++) begin
      r2    = {rem_c, num_c[W-1]};
      diff  = r2 - {1'b0, in_div};
      ge    = r2 >= {1'b0, in_div};
      rem_c = ge ? diff[DW-1:0] : r2[DW-1:0];
      num_c = {num_c[W-2:0], ge};
      if (ge && !lead_c.found) begin
        lead_c.found = 1'b1;
        lead_c.pos   = 8'(FIRST_BIT - j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_c;
      out_num  <= num_c;
      out_div  <= in_div;
      out_side <= in_side;
      out_lead <= lead_c;
    end
  end

endmodule

### src/dr_encode.sv
// Limit compare, compact re-encoding and final selection of the next target.
`timescale 1ns / 1ps

module dr_encode (
  input  logic [255:0]     quot,
  input  dr_pkg::lead_t    lead,
  input  dr_pkg::c3_side_t side,
  input  logic [31:0]      limit_compact,
  output logic [31:0]      next_compact
);

  dr_pkg::dec_t ld;
  logic [255:0] lim;
  logic [255:0] q;
  logic         found;
  logic [23:0]  mant;
  logic [7:0]   expo;
  logic [31:0]  enc;

  always_comb begin
    ld    = dr_pkg::decode(limit_compact);
    lim   = {233'd0, ld.mant} << ld.sh;
    q     = side.span_zero ? 256'd0 : quot;
    found = lead.found && !side.span_zero;
    // Keep the top three significant bytes; small targets are padded on the right.
    if (lead.pos[7:3] >= 5'd2) begin
      mant = 24'(q >> {lead.pos[7:3] - 5'd2, 3'b000});
    end else if (lead.pos[7:3] == 5'd1) begin
      mant = {q[15:0], 8'd0};
    end else begin
      mant = {q[7:0], 16'd0};
    end
    expo = {3'd0, lead.pos[7:3]} + 8'd1;
    if (mant[23]) begin
      mant = mant >> 8;
      expo = expo + 8'd1;
    end
    enc = found ? {expo, 1'b0, mant[22:0]} : 32'd0;

    if (!side.boundary || side.bad || !ld.ok) begin
      next_compact = side.prev;
    end else if (side.ovf || q > lim) begin
      next_compact = limit_compact;
    end else begin
      next_compact = enc;
    end
  end

endmodule

### src/difficulty_retarget.sv
// Top level: compact-target retarget pipeline built from chains of divider cells.
// Each word passes three chains of divider cells (5, 8 and 64 cells) and five plain stages.
// Throughput: one word per cycle unless out_ready holds the output; bubbles close up,
// as every stage moves on into a free slot.
// Reset clears every valid bit and loads the register defaults; payload stays unreset.
`timescale 1ns / 1ps

module difficulty_retarget (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] block_height,
  input  logic [31:0] prev_compact,
  input  logic [31:0] prev_time,
  input  logic [31:0] period_start_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_compact,
  output logic        is_boundary,
  output logic [31:0] start_height
);

  localparam int C1N = dr_pkg::SPW / dr_pkg::STEPS;
  localparam int C2N = dr_pkg::HW / dr_pkg::STEPS;
  localparam int C3N = dr_pkg::TW / dr_pkg::STEPS;
  localparam int C2SW = $bits(dr_pkg::c2_side_t);
  localparam int C3SW = $bits(dr_pkg::c3_side_t);
  localparam int HDRW = $bits(dr_pkg::hdr_t);

  logic [31:0] switch_height;
  logic [31:0] limit_compact;
  logic [19:0] span_before;
  logic [19:0] span_after;
  logic [19:0] block_spacing;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_height <= dr_pkg::RST_SWITCH_HEIGHT;
      limit_compact <= dr_pkg::RST_LIMIT_COMPACT;
      span_before   <= dr_pkg::RST_SPAN_BEFORE;
      span_after    <= dr_pkg::RST_SPAN_AFTER;
      block_spacing <= dr_pkg::RST_BLOCK_SPACING;
    end else if (cfg_write) begin
      case (cfg_index)
        dr_pkg::REG_SWITCH_HEIGHT: switch_height <= cfg_data;
        dr_pkg::REG_LIMIT_COMPACT: limit_compact <= cfg_data;
        dr_pkg::REG_SPAN_BEFORE:   span_before   <= cfg_data[19:0];
        dr_pkg::REG_SPAN_AFTER:    span_after    <= cfg_data[19:0];
        dr_pkg::REG_BLOCK_SPACING: block_spacing <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // ---------------- enables: a stage loads when empty or when its successor loads
  logic c1_en [0:C1N-1];
  logic c2_en [0:C2N-1];
  logic c3_en [0:C3N-1];
  logic en_b, en_c, en_d, en_e, en_f;

  logic                c1_v    [0:C1N];
  logic [19:0]         c1_rem  [0:C1N];
  logic [19:0]         c1_num  [0:C1N];
  logic [19:0]         c1_div  [0:C1N];
  logic [HDRW-1:0]     c1_side [0:C1N];

  logic                c2_v    [0:C2N];
  logic [19:0]         c2_rem  [0:C2N];
  logic [31:0]         c2_num  [0:C2N];
  logic [19:0]         c2_div  [0:C2N];
  logic [C2SW-1:0]     c2_side [0:C2N];

  logic                c3_v    [0:C3N];
  logic [19:0]         c3_rem  [0:C3N];
  logic [255:0]        c3_num  [0:C3N];
  logic [19:0]         c3_div  [0:C3N];
  logic [C3SW-1:0]     c3_side [0:C3N];
  dr_pkg::lead_t       c3_lead [0:C3N];

  logic b_v, c_v, d_v, e_v;

  assign en_f = !out_valid || out_ready;
  assign en_e = !e_v || c3_en[0];
  assign en_d = !d_v || en_e;
  assign en_c = !c_v || en_d;
  assign en_b = !b_v || en_c;
  assign in_ready = c1_en[0];

  genvar k;

  // ---------------- chain 1: period length = span_before / block_spacing
  dr_pkg::hdr_t in_hdr;
  always_comb begin
    in_hdr.h       = block_height;
    in_hdr.prev    = prev_compact;
    in_hdr.t_last  = prev_time;
    in_hdr.t_first = period_start_time;
  end

  assign c1_v[0]    = in_valid;
  assign c1_rem[0]  = 20'd0;
  assign c1_num[0]  = span_before;
  assign c1_div[0]  = block_spacing;
  assign c1_side[0] = in_hdr;

  generate
    for (k = 0; k < C1N; k++) begin : g_c1
      if (k == C1N - 1) begin : g_last
        assign c1_en[k] = !c1_v[k+1] || c2_en[0];
      end else begin : g_mid
        assign c1_en[k] = !c1_v[k+1] || c1_en[k+1];
      end
      dr_div_cell #(
        .W(dr_pkg::SPW), .DW(dr_pkg::SPW), .SW(HDRW),
        .FIRST_BIT(dr_pkg::SPW - 1 - k * dr_pkg::STEPS)
      ) u_cell (
        .clk(clk), .rst(rst), .en(c1_en[k]),
        .in_valid(c1_v[k]), .in_rem(c1_rem[k]), .in_num(c1_num[k]),
        .in_div(c1_div[k]), .in_side(c1_side[k]), .in_lead('0),
        .out_valid(c1_v[k+1]), .out_rem(c1_rem[k+1]), .out_num(c1_num[k+1]),
        .out_div(c1_div[k+1]), .out_side(c1_side[k+1]), .out_lead()
      );
    end
  endgenerate

  // ---------------- chain 2: height modulo period
  dr_pkg::hdr_t     h1;
  dr_pkg::c2_side_t s2_in;
  logic             single_step;
  logic [19:0]      interval;

  always_comb begin
    h1 = c1_side[C1N];
    single_step = (h1.h != 32'd0) && ((h1.h - 32'd1) >= switch_height);
    if (single_step) begin
      interval = 20'd1;
    end else if (block_spacing == 20'd0) begin
      interval = 20'd0;
    end else begin
      interval = c1_num[C1N];
    end
    s2_in.hdr      = h1;
    s2_in.interval = interval;
  end

  assign c2_v[0]    = c1_v[C1N];
  assign c2_rem[0]  = 20'd0;
  assign c2_num[0]  = h1.h;
  assign c2_div[0]  = interval;
  assign c2_side[0] = s2_in;

  generate
    for (k = 0; k < C2N; k++) begin : g_c2
      if (k == C2N - 1) begin : g_last
        assign c2_en[k] = !c2_v[k+1] || en_b;
      end else begin : g_mid
        assign c2_en[k] = !c2_v[k+1] || c2_en[k+1];
      end
      dr_div_cell #(
        .W(dr_pkg::HW), .DW(dr_pkg::SPW), .SW(C2SW),
        .FIRST_BIT(dr_pkg::HW - 1 - k * dr_pkg::STEPS)
      ) u_cell (
        .clk(clk), .rst(rst), .en(c2_en[k]),
        .in_valid(c2_v[k]), .in_rem(c2_rem[k]), .in_num(c2_num[k]),
        .in_div(c2_div[k]), .in_side(c2_side[k]), .in_lead('0),
        .out_valid(c2_v[k+1]), .out_rem(c2_rem[k+1]), .out_num(c2_num[k+1]),
        .out_div(c2_div[k+1]), .out_side(c2_side[k+1]), .out_lead()
      );
    end
  endgenerate

  // ---------------- stage B: boundary decision, span and bounds
  dr_pkg::c2_side_t s2;
  logic [31:0] hm1, iv32, back;
  logic        bnd;
  logic        damped;
  logic [19:0] span_sel;
  logic [21:0] lo_sel, hi_sel;

  logic               b_boundary, b_damped;
  logic [31:0]        b_start, b_prev;
  logic [19:0]        b_span;
  logic [21:0]        b_lo, b_hi;
  logic signed [33:0] b_actual;

  always_comb begin
    s2     = c2_side[C2N];
    hm1    = s2.hdr.h - 32'd1;
    iv32   = {12'd0, s2.interval};
    back   = (s2.hdr.h == iv32) ? iv32 - 32'd1 : iv32;
    bnd    = (s2.hdr.h != 32'd0) && (s2.interval != 20'd0) && (c2_rem[C2N] == 20'd0) &&
             (back <= hm1);
    damped = s2.hdr.h >= switch_height;
    span_sel = damped ? span_after : span_before;
    if (damped) begin
      lo_sel = {2'd0, span_sel} - {4'd0, span_sel[19:2]};
      hi_sel = {2'd0, span_sel} + {3'd0, span_sel[19:1]};
    end else begin
      hi_sel = {span_sel, 2'd0};
      if (s2.hdr.h > dr_pkg::HIGH_TIER) begin
        lo_sel = {4'd0, span_sel[19:2]};
      end else if (s2.hdr.h > dr_pkg::MID_TIER) begin
        lo_sel = {5'd0, span_sel[19:3]};
      end else begin
        lo_sel = {6'd0, span_sel[19:4]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en_b) begin
      b_v <= c2_v[C2N];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_boundary <= bnd;
      b_start    <= bnd ? hm1 - back : 32'd0;
      b_prev     <= s2.hdr.prev;
      b_damped   <= damped;
      b_span     <= span_sel;
      b_lo       <= lo_sel;
      b_hi       <= hi_sel;
      b_actual   <= $signed({2'd0, s2.hdr.t_last}) - $signed({2'd0, s2.hdr.t_first});
    end
  end

  // ---------------- stage C: damping, clamp and decode of the previous target
  logic signed [33:0] span34, x34, xt34, a34, lo34, hi34;
  logic [21:0]        clamped;

  logic               c_boundary;
  logic [31:0]        c_start, c_prev;
  logic [19:0]        c_span;
  logic [21:0]        c_actual;
  dr_pkg::dec_t       c_dec;

  always_comb begin
    span34 = $signed({14'd0, b_span});
    lo34   = $signed({12'd0, b_lo});
    hi34   = $signed({12'd0, b_hi});
    x34    = b_actual - span34;
    // Arithmetic shift rounds down; bias negative values so the quotient truncates toward zero.
    xt34   = (x34 + (x34[33] ? 34'sd7 : 34'sd0)) >>> 3;
    a34    = b_damped ? span34 + xt34 : b_actual;
    if (a34 < lo34) begin
      clamped = b_lo;
    end else if (a34 > hi34) begin
      clamped = b_hi;
    end else begin
      clamped = a34[21:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en_c) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_boundary <= b_boundary;
      c_start    <= b_start;
      c_prev     <= b_prev;
      c_span     <= b_span;
      c_actual   <= clamped;
      c_dec      <= dr_pkg::decode(b_prev);
    end
  end

  // ---------------- stage D: mantissa times clamped time
  logic        d_boundary, d_ok;
  logic [31:0] d_start, d_prev;
  logic [19:0] d_span;
  logic [7:0]  d_sh;
  logic [44:0] d_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en_d) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_boundary <= c_boundary;
      d_start    <= c_start;
      d_prev     <= c_prev;
      d_span     <= c_span;
      d_sh       <= c_dec.sh;
      d_ok       <= c_dec.ok;
      d_prod     <= {22'd0, c_dec.mant} * {23'd0, c_actual};
    end
  end

  // ---------------- stage E: place the product in the 256-bit word, check overflow
  logic [300:0]     wide;
  dr_pkg::c3_side_t s3_in;

  logic [255:0]     e_x;
  logic [19:0]      e_span;
  dr_pkg::c3_side_t e_side;

  always_comb begin
    wide = {256'd0, d_prod} << d_sh;
    s3_in.boundary  = d_boundary;
    s3_in.start     = d_start;
    s3_in.prev      = d_prev;
    s3_in.bad       = !d_ok;
    s3_in.ovf       = |wide[300:256];
    s3_in.span_zero = d_span == 20'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en_e) begin
      e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_x    <= wide[255:0];
      e_span <= d_span;
      e_side <= s3_in;
    end
  end

  // ---------------- chain 3: scaled target divided by span
  assign c3_v[0]    = e_v;
  assign c3_rem[0]  = 20'd0;
  assign c3_num[0]  = e_x;
  assign c3_div[0]  = e_span;
  assign c3_side[0] = e_side;
  assign c3_lead[0] = '0;

  generate
    for (k = 0; k < C3N; k++) begin : g_c3
      if (k == C3N - 1) begin : g_last
        assign c3_en[k] = !c3_v[k+1] || en_f;
      end else begin : g_mid
        assign c3_en[k] = !c3_v[k+1] || c3_en[k+1];
      end
      dr_div_cell #(
        .W(dr_pkg::TW), .DW(dr_pkg::SPW), .SW(C3SW),
        .FIRST_BIT(dr_pkg::TW - 1 - k * dr_pkg::STEPS)
      ) u_cell (
        .clk(clk), .rst(rst), .en(c3_en[k]),
        .in_valid(c3_v[k]), .in_rem(c3_rem[k]), .in_num(c3_num[k]),
        .in_div(c3_div[k]), .in_side(c3_side[k]), .in_lead(c3_lead[k]),
        .out_valid(c3_v[k+1]), .out_rem(c3_rem[k+1]), .out_num(c3_num[k+1]),
        .out_div(c3_div[k+1]), .out_side(c3_side[k+1]), .out_lead(c3_lead[k+1])
      );
    end
  endgenerate

  // ---------------- output register
  dr_pkg::c3_side_t s3;
  logic [31:0]      next_c;

  assign s3 = c3_side[C3N];

  dr_encode u_encode (
    .quot(c3_num[C3N]),
    .lead(c3_lead[C3N]),
    .side(s3),
    .limit_compact(limit_compact),
    .next_compact(next_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_f) begin
      out_valid <= c3_v[C3N];
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      next_compact <= next_c;
      is_boundary  <= s3.boundary;
      start_height <= s3.start;
    end
  end

endmodule
